// File: hdl/tcmd_pkg.sv
// Shared constants and types for the track to cluster distance unit.
`timescale 1ns / 1ps
`default_nettype none
package tcmd_pkg;
  localparam int POS_BITS_DEF = 18;
  localparam int LAYER_BITS_DEF = 7;
  localparam int CFG_POINT_BITS = 18;
  localparam int DIR_BITS = 16;
  localparam int DIST_BITS = 20;
  localparam int PERP_BITS = 42;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 18;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam logic [PERP_BITS-1:0] PERP_MAX = '1;
  localparam logic [DIST_BITS-1:0] CUT_LIMIT = 20'd1600;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POINT_X = 3'd0, REG_POINT_Y = 3'd1, REG_POINT_Z = 3'd2,
    REG_DIR_X = 3'd3, REG_DIR_Y = 3'd4, REG_DIR_Z = 3'd5,
    REG_MAX_LAYER = 3'd6, REG_AGREES = 3'd7
  } cfg_reg_t;

  // One classified hit as it leaves the front part.
  typedef struct packed {
    logic use_hit;
    logic last;
    logic [DIST_BITS-1:0] par;
    logic [PERP_BITS-1:0] perp;
    logic cut_pass;
  } hit_word_t;
endpackage
`default_nettype wire

// File: hdl/tcmd_if.sv
// Valid/ready stream interfaces for hits, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface tcmd_hit_if #(parameter int PositionBits = 18, parameter int LayerBits = 7);
  logic valid;
  logic ready;
  logic signed [PositionBits-1:0] hit_x;
  logic signed [PositionBits-1:0] hit_y;
  logic signed [PositionBits-1:0] hit_z;
  logic [LayerBits-1:0] hit_layer;
  logic last_hit;
  modport source(output valid, hit_x, hit_y, hit_z, hit_layer, last_hit, input ready);
  modport sink(input valid, hit_x, hit_y, hit_z, hit_layer, last_hit, output ready);
endinterface

interface tcmd_res_if;
  logic valid;
  logic ready;
  logic [19:0] perp_distance;
  logic [19:0] perp_distance_cut;
  logic [19:0] parallel_distance;
  logic any_found;
  logic cut_found;
  modport source(output valid, perp_distance, perp_distance_cut, parallel_distance,
    any_found, cut_found, input ready);
  modport sink(input valid, perp_distance, perp_distance_cut, parallel_distance,
    any_found, cut_found, output ready);
endinterface

interface tcmd_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [17:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/tcmd_front.sv
// Front part: layer checks and the per-hit distance pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tcmd_front #(
  parameter int PositionBits = tcmd_pkg::POS_BITS_DEF,
  parameter int LayerBits = tcmd_pkg::LAYER_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [PositionBits-1:0] hit_x,
  input  wire logic signed [PositionBits-1:0] hit_y,
  input  wire logic signed [PositionBits-1:0] hit_z,
  input  wire logic [LayerBits-1:0] hit_layer,
  input  wire logic last_hit,
  input  wire logic signed [tcmd_pkg::CFG_POINT_BITS-1:0] point_x,
  input  wire logic signed [tcmd_pkg::CFG_POINT_BITS-1:0] point_y,
  input  wire logic signed [tcmd_pkg::CFG_POINT_BITS-1:0] point_z,
  input  wire logic signed [tcmd_pkg::DIR_BITS-1:0] dir_x,
  input  wire logic signed [tcmd_pkg::DIR_BITS-1:0] dir_y,
  input  wire logic signed [tcmd_pkg::DIR_BITS-1:0] dir_z,
  input  wire logic [6:0] max_layer,
  input  wire logic agrees,
  output logic out_valid,
  input  wire logic out_ready,
  output tcmd_pkg::hit_word_t out_word
);
  import tcmd_pkg::*;
  localparam int DB = (PositionBits > CFG_POINT_BITS ? PositionBits : CFG_POINT_BITS) + 1;
  localparam int PB = DB + DIR_BITS;
  localparam int SB = PB + 2;
  localparam int MB = SB - 15 + 1;
  localparam int QB = 2 * MB + 2;
  localparam int LB = (LayerBits > 7 ? LayerBits : 7);

  // Stage enables: the whole pipe moves together.
  logic adv;
  logic v1, v2, v3, v4;
  assign adv = !v4 || out_ready;
  assign in_ready = adv;
  assign out_valid = v4;

  // Layer tracking runs at acceptance so stop decisions follow hit order.
  logic stopped;
  logic [LayerBits-1:0] prev_layer;
  logic take, use_now;
  assign take = in_valid && in_ready;
  always_comb begin
    use_now = !stopped && !(LB'(hit_layer) > LB'(max_layer)) && !(hit_layer < prev_layer);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
      prev_layer <= '0;
    end else if (take) begin
      if (last_hit) begin
        stopped <= 1'b0;
        prev_layer <= '0;
      end else if (use_now) begin
        prev_layer <= hit_layer;
      end else begin
        stopped <= 1'b1;
      end
    end
  end

  // Stage 1: differences from the track point.
  logic u1, l1;
  logic signed [DB-1:0] dx, dy, dz;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= take;
    if (adv) begin
      u1 <= use_now;
      l1 <= last_hit;
      dx <= DB'(hit_x) - DB'(point_x);
      dy <= DB'(hit_y) - DB'(point_y);
      dz <= DB'(hit_z) - DB'(point_z);
    end
  end

  // Stage 2: the nine products, one register after them.
  logic u2, l2;
  logic signed [PB-1:0] pxx, pyy, pzz, pyz, pzy, pzx, pxz, pxy, pyx;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      u2 <= u1; l2 <= l1;
      pxx <= PB'(dir_x) * PB'(dx); pyy <= PB'(dir_y) * PB'(dy);
      pzz <= PB'(dir_z) * PB'(dz);
      pyz <= PB'(dir_y) * PB'(dz); pzy <= PB'(dir_z) * PB'(dy);
      pzx <= PB'(dir_z) * PB'(dx); pxz <= PB'(dir_x) * PB'(dz);
      pxy <= PB'(dir_x) * PB'(dy); pyx <= PB'(dir_y) * PB'(dx);
    end
  end

  function automatic logic [MB-1:0] round_mag(input logic signed [SB-1:0] v);
    logic [SB-1:0] m;
    logic [SB:0] r;
    m = v[SB-1] ? SB'(-v) : SB'(v);
    r = {1'b0, m} + (SB+1)'(1 << 14);
    return MB'(r >> 15);
  endfunction

  // Stage 3: sums and rounding.
  logic u3, l3;
  logic [MB-1:0] par_m, cx, cy, cz;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      u3 <= u2; l3 <= l2;
      par_m <= round_mag(SB'(pxx) + SB'(pyy) + SB'(pzz));
      cx <= round_mag(SB'(pyz) - SB'(pzy));
      cy <= round_mag(SB'(pzx) - SB'(pxz));
      cz <= round_mag(SB'(pxy) - SB'(pyx));
    end
  end

  // Stage 4: squares, saturation and the cut.
  logic [QB-1:0] perp_sum;
  logic [DIST_BITS-1:0] par_sat;
  always_comb begin
    perp_sum = QB'(cx) * QB'(cx) + QB'(cy) * QB'(cy) + QB'(cz) * QB'(cz);
    par_sat = (par_m > MB'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(par_m);
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      out_word.use_hit <= u3;
      out_word.last <= l3;
      out_word.par <= par_sat;
      out_word.perp <= (perp_sum > QB'(PERP_MAX)) ? PERP_MAX : PERP_BITS'(perp_sum);
      out_word.cut_pass <= (par_sat < CUT_LIMIT) && agrees;
    end
  end
endmodule
`default_nettype wire

// File: hdl/tcmd_fifo.sv
// Short queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none
module tcmd_fifo (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire tcmd_pkg::hit_word_t in_word,
  output logic out_valid,
  input  wire logic out_ready,
  output tcmd_pkg::hit_word_t out_word
);
  import tcmd_pkg::*;
  hit_word_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic wr, rd;
  assign in_ready = cnt != 3'd4;
  assign out_valid = cnt != 3'd0;
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;
  assign out_word = mem[rp];
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_word;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end
endmodule
`default_nettype wire

// File: hdl/tcmd_sqrt.sv
// Iterative integer square root, one result bit from two radicand bits a cycle.
`timescale 1ns / 1ps
`default_nettype none
module tcmd_sqrt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [tcmd_pkg::PERP_BITS-1:0] radicand,
  output logic busy,
  output logic [tcmd_pkg::PERP_BITS/2-1:0] root
);
  import tcmd_pkg::*;
  localparam int RB = PERP_BITS / 2;
  logic [PERP_BITS-1:0] rem_v;
  logic [PERP_BITS-1:0] res;
  logic [PERP_BITS-1:0] bitv;
  logic [PERP_BITS-1:0] trial;
  assign trial = res + bitv;
  assign root = RB'(res);
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem_v <= radicand;
      res <= '0;
      bitv <= PERP_BITS'(1) << (PERP_BITS - 2);
    end else if (busy) begin
      if (rem_v >= trial) begin
        rem_v <= rem_v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv == PERP_BITS'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: hdl/tcmd_back.sv
// Back part: minimum tracking and the end-of-cluster result.
`timescale 1ns / 1ps
`default_nettype none
module tcmd_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire tcmd_pkg::hit_word_t in_word,
  output logic res_valid,
  input  wire logic res_ready,
  output logic [19:0] perp_distance,
  output logic [19:0] perp_distance_cut,
  output logic [19:0] parallel_distance,
  output logic any_found,
  output logic cut_found
);
  import tcmd_pkg::*;
  typedef enum logic [3:0] {
    ST_RUN = 4'b0001, ST_ROOT_A = 4'b0010, ST_ROOT_B = 4'b0100, ST_DONE = 4'b1000
  } state_t;
  state_t state;
  logic [DIST_BITS-1:0] min_par;
  logic [PERP_BITS-1:0] min_perp, min_cut;
  logic any_f, cut_f;
  logic take, sq_start, sq_busy, root_ready;
  logic [PERP_BITS-1:0] sq_in;
  logic [PERP_BITS/2-1:0] sq_root;

  assign in_ready = (state == ST_RUN) && !res_valid;
  assign take = in_valid && in_ready;
  assign root_ready = !sq_start && !sq_busy;

  tcmd_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .busy(sq_busy), .root(sq_root));

  // Root start pulse: once for the plain minimum, once for the cut minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_start <= 1'b0;
    end else begin
      sq_start <= ((state == ST_RUN) && take && in_word.last) ||
                  ((state == ST_ROOT_A) && root_ready);
    end
  end

  // Minima update, then two roots run on the shared unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      res_valid <= 1'b0;
      min_par <= DIST_MAX; min_perp <= PERP_MAX; min_cut <= PERP_MAX;
      any_f <= 1'b0; cut_f <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        ST_RUN: begin
          if (take) begin
            if (in_word.use_hit) begin
              any_f <= 1'b1;
              if (in_word.par < min_par) min_par <= in_word.par;
              if (in_word.perp < min_perp) min_perp <= in_word.perp;
              if (in_word.cut_pass) begin
                cut_f <= 1'b1;
                if (in_word.perp < min_cut) min_cut <= in_word.perp;
              end
            end
            if (in_word.last) state <= ST_ROOT_A;
          end
        end
        ST_ROOT_A: begin
          if (root_ready) begin
            perp_distance <= sq_root[DIST_BITS] ? DIST_MAX : sq_root[DIST_BITS-1:0];
            state <= ST_ROOT_B;
          end
        end
        ST_ROOT_B: begin
          if (root_ready) begin
            perp_distance_cut <= sq_root[DIST_BITS] ? DIST_MAX : sq_root[DIST_BITS-1:0];
            parallel_distance <= min_par;
            any_found <= any_f;
            cut_found <= cut_f;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          res_valid <= 1'b1;
          state <= ST_RUN;
          min_par <= DIST_MAX; min_perp <= PERP_MAX; min_cut <= PERP_MAX;
          any_f <= 1'b0; cut_f <= 1'b0;
        end
        default: state <= ST_RUN;
      endcase
    end
  end
  assign sq_in = (state == ST_ROOT_A) ? min_perp : min_cut;

  a_cut_implies_any: assert property (@(posedge clk) disable iff (rst)
    cut_f |-> any_f) else $error("cut flag without any flag");
  a_no_take_while_rooting: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !take) else $error("hit taken during root");
  a_cut_min_bound: assert property (@(posedge clk) disable iff (rst)
    (min_cut != PERP_MAX) |-> (min_perp <= min_cut)) else $error("cut minimum below minimum");
endmodule
`default_nettype wire

// File: hdl/track_cluster_min_distance_unit.sv
// Top level of the track to cluster minimum distance unit.
`timescale 1ns / 1ps
`default_nettype none
// Hits stream through a four-stage distance pipeline at one per cycle, unless
// stalled by back-pressure, into a four-deep queue; the back part folds one hit
// a cycle into the minima while it is in its run state and no result is pending.
// On a last hit the back part runs two 21-step square roots on one shared unit
// and then raises the result; hits after a last hit wait in the pipeline and
// queue until the result has been taken.
module track_cluster_min_distance_unit #(
  parameter int PositionBits = tcmd_pkg::POS_BITS_DEF,
  parameter int LayerBits = tcmd_pkg::LAYER_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  tcmd_hit_if.sink hits,
  tcmd_res_if.source results,
  tcmd_cfg_if.sink cfg
);
  import tcmd_pkg::*;
  logic signed [CFG_POINT_BITS-1:0] point_x, point_y, point_z;
  logic signed [DIR_BITS-1:0] dir_x, dir_y, dir_z;
  logic [6:0] max_layer;
  logic agrees;
  logic f_valid, f_ready, q_valid, q_ready;
  hit_word_t f_word, q_word;

  // Register writes.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0; point_y <= '0; point_z <= '0;
      dir_x <= 16'sd32767; dir_y <= '0; dir_z <= '0;
      max_layer <= 7'd127; agrees <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_POINT_X: point_x <= cfg.data;
        REG_POINT_Y: point_y <= cfg.data;
        REG_POINT_Z: point_z <= cfg.data;
        REG_DIR_X: dir_x <= cfg.data[DIR_BITS-1:0];
        REG_DIR_Y: dir_y <= cfg.data[DIR_BITS-1:0];
        REG_DIR_Z: dir_z <= cfg.data[DIR_BITS-1:0];
        REG_MAX_LAYER: max_layer <= cfg.data[6:0];
        REG_AGREES: agrees <= cfg.data[0];
        default: ;
      endcase
    end
  end

  tcmd_front #(.PositionBits(PositionBits), .LayerBits(LayerBits)) u_front (
    .clk(clk), .rst(rst), .in_valid(hits.valid), .in_ready(hits.ready),
    .hit_x(hits.hit_x), .hit_y(hits.hit_y), .hit_z(hits.hit_z),
    .hit_layer(hits.hit_layer), .last_hit(hits.last_hit),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .max_layer(max_layer),
    .agrees(agrees), .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word));

  tcmd_fifo u_fifo (.clk(clk), .rst(rst), .in_valid(f_valid), .in_ready(f_ready),
    .in_word(f_word), .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word));

  tcmd_back u_back (.clk(clk), .rst(rst), .in_valid(q_valid), .in_ready(q_ready),
    .in_word(q_word), .res_valid(results.valid), .res_ready(results.ready),
    .perp_distance(results.perp_distance), .perp_distance_cut(results.perp_distance_cut),
    .parallel_distance(results.parallel_distance), .any_found(results.any_found),
    .cut_found(results.cut_found));
endmodule
`default_nettype wire
